### rtl/core/triangle_fade_envelope_gain_defines.svh
// Assertion macros shared by the fade envelope RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TRIANGLE_FADE_ENVELOPE_GAIN_DEFINES_SVH
`define TRIANGLE_FADE_ENVELOPE_GAIN_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TFEG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TFEG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tfeg_pkg.sv
// Shared widths and reset values for the triangle fade envelope gain block.
// No dependencies; imported by tfeg_div and the top level.
`default_nettype none

package tfeg_pkg;

    localparam int FADE_W          = 17;   // ramp length register
    localparam int POS_W           = 17;   // envelope position counter
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [FADE_W-1:0] FADE_RESET = 17'd22050;

endpackage

`default_nettype wire

### rtl/core/tfeg_div.sv
// Shared unsigned restoring divider, two quotient bits per cycle.
// Depends on tfeg_pkg for the divisor width.
`default_nettype none

module tfeg_div #(
    parameter int DIVIDEND_W = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [DIVIDEND_W-1:0]       i_dividend,
    input  wire logic [tfeg_pkg::FADE_W-1:0] i_divisor,
    output logic                             o_busy,
    output logic [DIVIDEND_W-1:0]            o_quotient
);
    import tfeg_pkg::*;

    localparam int DIV_W = DIVIDEND_W + (DIVIDEND_W % 2);
    localparam int STEPS = DIV_W / 2;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [FADE_W-1:0] r_rem;
    logic [FADE_W-1:0] n_rem;
    logic [DIV_W-1:0]  r_work;      // dividend bits shift out the top, quotient in the bottom
    logic [DIV_W-1:0]  n_work;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;

    logic [FADE_W:0]   t1;
    logic [FADE_W:0]   t2;
    logic [FADE_W-1:0] rem1;
    logic              q1;
    logic              q2;

    always_comb begin
        t1   = {r_rem, r_work[DIV_W-1]};
        q1   = (t1 >= {1'b0, i_divisor});
        rem1 = q1 ? FADE_W'(t1 - {1'b0, i_divisor}) : t1[FADE_W-1:0];
        t2   = {rem1, r_work[DIV_W-2]};
        q2   = (t2 >= {1'b0, i_divisor});
        n_rem  = q2 ? FADE_W'(t2 - {1'b0, i_divisor}) : t2[FADE_W-1:0];
        n_work = {r_work[DIV_W-3:0], q1, q2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_work <= DIV_W'(i_dividend);
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_work <= n_work;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_work[DIVIDEND_W-1:0];

endmodule

`default_nettype wire

### rtl/core/triangle_fade_envelope_gain.sv
// Triangle fade envelope gain: each stereo item is scaled by position/fade_samples,
// truncated toward zero and clamped; the position then ramps up and down between 0
// and fade_samples. Each item runs a multiply and a shared two-bit-per-cycle
// divider per channel, left then right. s_axis_tready is high only between items
// and drops while a fade_samples write is offered; writes are taken only between
// items. The finished result sits in an output register, so the next item can be
// taken while it waits. A fade_samples of zero gives zero outputs. Depends on
// tfeg_pkg and tfeg_div.
`default_nettype none

`include "triangle_fade_envelope_gain_defines.svh"

module triangle_fade_envelope_gain #(
    parameter int SAMPLE_BITS = tfeg_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // config: fade_samples
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [tfeg_pkg::FADE_W-1:0]           i_cfg_data,
    // input items
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata, low to high: left_in, right_in, zero fill to bytes
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // result items
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // tdata, low to high: left_out, right_out, zero fill to bytes
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata
);
    import tfeg_pkg::*;

    localparam int TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int MAG_W   = SAMPLE_BITS + POS_W - 1;
    localparam int PROD_W  = SAMPLE_BITS + POS_W;

    localparam logic [MAG_W-1:0] MAG_MAX_POS = MAG_W'({(SAMPLE_BITS-1){1'b1}});
    localparam logic [MAG_W-1:0] MAG_MAX_NEG = MAG_MAX_POS + MAG_W'(1);
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL_L = 3'd1;
    localparam logic [2:0] S_DIV_L = 3'd2;
    localparam logic [2:0] S_MUL_R = 3'd3;
    localparam logic [2:0] S_DIV_R = 3'd4;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [FADE_W-1:0]      r_fade;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       n_pos;
    logic                   r_falling;
    logic                   n_falling;
    logic                   r_out_valid;

    logic [SAMPLE_BITS-1:0] r_smp_l;
    logic [SAMPLE_BITS-1:0] r_smp_r;
    logic                   r_neg;
    logic [SAMPLE_BITS-1:0] r_res_l;
    logic [SAMPLE_BITS-1:0] r_out_l;
    logic [SAMPLE_BITS-1:0] r_out_r;

    logic [SAMPLE_BITS-1:0] cur_smp;
    logic [SAMPLE_BITS-1:0] cur_abs;
    logic [PROD_W-1:0]      prod_full;
    logic [MAG_W-1:0]       mul_mag;
    logic                   div_start;
    logic                   div_busy;
    logic [MAG_W-1:0]       div_quo;
    logic [SAMPLE_BITS-1:0] scaled;
    logic                   in_accept;
    logic                   out_free;
    logic                   out_load;

    function automatic logic [SAMPLE_BITS-1:0] clamp_q(
        input logic             neg,
        input logic [MAG_W-1:0] q,
        input logic             fade_zero
    );
        logic [MAG_W-1:0] nq;
        nq = ~q + MAG_W'(1);
        if (fade_zero) begin
            return '0;
        end else if (neg) begin
            return (q > MAG_MAX_NEG) ? SMP_MIN : nq[SAMPLE_BITS-1:0];
        end else begin
            return (q > MAG_MAX_POS) ? SMP_MAX : q[SAMPLE_BITS-1:0];
        end
    endfunction

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    // a pending ramp-length write goes ahead of the next item
    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign out_load      = (r_state == S_DIV_R) && !div_busy && out_free;

    // magnitude times position; sign is reapplied after the divide
    assign cur_smp   = (r_state == S_MUL_L) ? r_smp_l : r_smp_r;
    assign cur_abs   = cur_smp[SAMPLE_BITS-1] ? (~cur_smp + SAMPLE_BITS'(1)) : cur_smp;
    assign prod_full = {{POS_W{1'b0}}, cur_abs} * {{SAMPLE_BITS{1'b0}}, r_pos};
    assign mul_mag   = prod_full[MAG_W-1:0];
    assign div_start = (r_state == S_MUL_L) || (r_state == S_MUL_R);
    assign scaled    = clamp_q(r_neg, div_quo, (r_fade == '0));

    tfeg_div #(
        .DIVIDEND_W (MAG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_mag),
        .i_divisor  (r_fade),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_accept) n_state = S_MUL_L;
            S_MUL_L: n_state = S_DIV_L;
            S_DIV_L: if (!div_busy) n_state = S_MUL_R;
            S_MUL_R: n_state = S_DIV_R;
            S_DIV_R: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // envelope step: turn to falling at the top, back to rising at zero
    always_comb begin
        n_pos     = r_falling ? (r_pos - POS_W'(1)) : (r_pos + POS_W'(1));
        n_falling = r_falling;
        if ({{(POS_W > FADE_W ? 1 : FADE_W - POS_W + 1){1'b0}}, n_pos} >=
            {{(FADE_W > POS_W ? 1 : POS_W - FADE_W + 1){1'b0}}, r_fade}) begin
            n_falling = 1'b1;
        end
        if (n_pos == '0) begin
            n_falling = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fade      <= FADE_RESET;
            r_pos       <= '0;
            r_falling   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fade <= i_cfg_data;
            end
            if (out_load) begin
                r_pos       <= n_pos;
                r_falling   <= n_falling;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_smp_l <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_smp_r <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        if (div_start) begin
            r_neg <= cur_smp[SAMPLE_BITS-1];
        end
        if ((r_state == S_DIV_L) && !div_busy) begin
            r_res_l <= scaled;
        end
        if (out_load) begin
            r_out_l <= r_res_l;
            r_out_r <= scaled;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'({r_out_r, r_out_l});

    `TFEG_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, !s_axis_tready,
        "item accepted but block still ready")
    `TFEG_ASSERT_IMP(a_div_in_div_state, i_clk, i_rst_n, div_busy,
        (r_state == S_DIV_L) || (r_state == S_DIV_R), "divider running outside a divide state")
    `TFEG_ASSERT_NXT(a_pos_steps_on_load, i_clk, i_rst_n, out_load,
        (r_pos != $past(r_pos)) && m_axis_tvalid, "result loaded without envelope step")
    `TFEG_ASSERT_IMP(a_no_fall_at_zero, i_clk, i_rst_n, r_falling, r_pos != '0,
        "falling with position at zero")

endmodule

`default_nettype wire
